@@ hw/rtl/arbc_pkg.sv @@
// Shared types, codes and constants for the actuator ramp/brake controller.
// Depends on nothing; used by actuator_ramp_brake_controller_top.
`timescale 1ns / 1ps

package arbc_pkg;

    localparam int DUTY_W = 16;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;
    localparam int DIV_W  = 24;
    localparam int REM_W  = 16;
    localparam int CNT_W  = 5;
    localparam int PROD_W = 40;
    localparam int FLAG_W = 5;

    // pending flag bit positions
    localparam int FL_POS  = 0;
    localparam int FL_UP   = 1;
    localparam int FL_BRK  = 2;
    localparam int FL_PWM  = 3;
    localparam int FL_SLOW = 4;

    localparam logic [FLAG_W-1:0] FLAGS_ALL = 5'h1f;

    // request codes
    localparam logic [1:0] REQ_IDLE = 2'd0;
    localparam logic [1:0] REQ_UP   = 2'd1;
    localparam logic [1:0] REQ_DOWN = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_DUTY_TOP     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_MIN_SPEED    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_POSITION = 3'd2;
    localparam logic [IDX_W-1:0] CFG_PRESET_POS   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_SET_VOLTAGE  = 3'd4;

    localparam logic [DUTY_W-1:0] RST_DUTY_TOP     = 16'd1000;
    localparam logic [DUTY_W-1:0] RST_MIN_SPEED    = 16'd100;
    localparam logic [DUTY_W-1:0] RST_MAX_POSITION = 16'd4000;
    localparam logic [DUTY_W-1:0] RST_PRESET_POS   = 16'd4000;
    localparam logic [CFG_W-1:0]  RST_SET_VOLTAGE  = 24'd240000;

    localparam logic [DUTY_W-1:0] BRAKE_BIAS  = 16'd3;
    localparam logic [DUTY_W-1:0] RATE_DIV    = 16'd20;
    localparam logic [DUTY_W-1:0] ROCK_MARGIN = 16'd10;
    localparam logic [DUTY_W-1:0] VOLT_SCALE  = 16'd100;
    localparam logic [DUTY_W-1:0] ROUND_HALF  = 16'd50;
    localparam logic [DUTY_W-1:0] SAT_DUTY    = 16'hffff;
    // 65536 * 100: products at or above this saturate
    localparam logic [PROD_W-1:0] SAT_PROD    = 40'd6553600;

    localparam logic [CNT_W-1:0] STEPS_SPEED = 5'd16;
    localparam logic [CNT_W-1:0] STEPS_FULL  = 5'd24;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_BRAKE,
        ST_COMP,
        ST_MUL,
        ST_CHK,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        DOP_BRAKE,
        DOP_VOLT,
        DOP_HUND
    } divop_t;

    typedef struct packed {
        logic [1:0]        req;
        logic              up_lim;
        logic              down_lim;
        logic              slide_back;
        logic              slide_fwd;
        logic              rocking;
        logic              rock_en;
        logic [DUTY_W-1:0] volts;
        logic              fault;
    } item_t;

endpackage

@@ hw/rtl/actuator_ramp_brake_controller_top.sv @@
// Actuator ramp/brake controller: sequencer plus one shared restoring divider.
// Depends on arbc_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_stall): one item is one control call. in_stall is
//   high from the accepting edge until that item's result is loaded into the
//   output register; the next item can be taken the cycle after.
//   Output channel (out_valid/out_stall): one result item per input item, held
//   in an output register. A finished result waits in the sequencer's last
//   step while the previous result is still stalled.
//   Steps: decide; for an end-limit brake, 16 shared divider steps (speed / 20)
//   and brake; clamp/compare; when the duty is voltage-compensated, 24 steps
//   for set_voltage / supply_voltage, multiply, saturation check, 24 more for
//   the divide by 100 and rounding; then finish.
//   Config (cfg_we/cfg_index/cfg_data) is taken at any edge with cfg_we high;
//   write it only while no item is in flight. Unknown indexes are ignored.
//   Reset: all motion state clears, registers take their default values, no
//   result is pending.
module actuator_ramp_brake_controller_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [arbc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [arbc_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             tick,
    input  logic [1:0]                       requested_state,
    input  logic                             up_limit,
    input  logic                             down_limit,
    input  logic                             slide_back_limit,
    input  logic                             slide_fwd_limit,
    input  logic                             rocking,
    input  logic                             rock_enable,
    input  logic [arbc_pkg::DUTY_W-1:0]      supply_voltage,
    input  logic                             fault,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [arbc_pkg::DUTY_W-1:0]      duty,
    output logic [arbc_pkg::DUTY_W-1:0]      speed,
    output logic                             direction_down,
    output logic                             decay_fast,
    output logic                             reset_released,
    output logic                             reset_pulse,
    output logic                             done_res,
    output logic [arbc_pkg::DUTY_W-1:0]      position,
    output logic                             preset_valid,
    output logic [arbc_pkg::DUTY_W-1:0]      preset_value
);

    arbc_pkg::state_t state_reg, state_next;

    logic [arbc_pkg::DUTY_W-1:0] duty_top_reg, min_speed_reg, max_position_reg, preset_pos_reg;
    logic [arbc_pkg::CFG_W-1:0]  set_voltage_reg;

    logic [1:0]                  motion_reg, motion_next;
    logic [arbc_pkg::DUTY_W-1:0] speed_reg, speed_next;
    logic [arbc_pkg::DUTY_W-1:0] applied_reg, applied_next;
    logic                        phase_reg, phase_next;
    logic                        decay_reg, decay_next;
    logic                        rline_reg, rline_next;
    logic [arbc_pkg::DUTY_W-1:0] pos_reg, pos_next;
    logic [arbc_pkg::FLAG_W-1:0] flags_reg, flags_next;
    logic                        out_valid_reg, out_valid_next;

    arbc_pkg::item_t             item_reg, item_next;
    logic                        done_reg, done_next;
    logic [arbc_pkg::DUTY_W-1:0] comp_reg, comp_next;
    logic [arbc_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [arbc_pkg::REM_W-1:0]  div_rem_reg, div_rem_next;
    logic [arbc_pkg::DIV_W-1:0]  div_quo_reg, div_quo_next;
    logic [arbc_pkg::REM_W-1:0]  div_den_reg, div_den_next;
    logic [arbc_pkg::CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    arbc_pkg::divop_t            div_op_reg, div_op_next;

    logic [arbc_pkg::DUTY_W-1:0] o_duty_reg, o_duty_next;
    logic [arbc_pkg::DUTY_W-1:0] o_speed_reg, o_speed_next;
    logic                        o_dir_reg, o_dir_next;
    logic                        o_decay_reg, o_decay_next;
    logic                        o_rrel_reg, o_rrel_next;
    logic                        o_pulse_reg, o_pulse_next;
    logic                        o_done_reg, o_done_next;
    logic [arbc_pkg::DUTY_W-1:0] o_pos_reg, o_pos_next;
    logic                        o_pvalid_reg, o_pvalid_next;
    logic [arbc_pkg::DUTY_W-1:0] o_pval_reg, o_pval_next;

    logic in_accept;
    logic commit;

    // decision terms
    logic slide, any_end, reversal;
    logic do_brake, brake_end, zero_after, do_up, do_slow;
    logic brake_live, brake_div, item_done;

    // arithmetic
    logic [arbc_pkg::REM_W:0]    rem_sh;
    logic                        div_ge;
    logic [arbc_pkg::DUTY_W-1:0] up_base, up_val;
    logic [arbc_pkg::DUTY_W:0]   up_two;
    logic [arbc_pkg::DUTY_W-1:0] slow_val;
    logic [arbc_pkg::DUTY_W:0]   brake_dec;
    logic [arbc_pkg::DUTY_W-1:0] brake_val;
    logic [arbc_pkg::DUTY_W-1:0] clamp_val;
    logic [22:0]                 volt_scaled;
    logic [arbc_pkg::PROD_W-1:0] prod_calc;
    logic [arbc_pkg::DUTY_W:0]   round_val;

    assign in_accept = in_valid && (state_reg == arbc_pkg::ST_IDLE);
    assign in_stall  = (state_reg != arbc_pkg::ST_IDLE);
    assign commit    = (state_reg == arbc_pkg::ST_FINISH) && (!out_valid_reg || !out_stall);

    // ---------------- decision ----------------
    always_comb
    begin
        slide      = item_reg.slide_back && item_reg.slide_fwd;
        any_end    = item_reg.up_lim || item_reg.down_lim;
        reversal   = (motion_reg != item_reg.req) && (motion_reg != arbc_pkg::REQ_IDLE);
        do_brake   = 1'b0;
        brake_end  = any_end;
        zero_after = 1'b0;
        do_up      = 1'b0;
        do_slow    = 1'b0;
        item_done  = 1'b0;
        if (slide)
        begin
            do_brake  = 1'b1;
            item_done = 1'b1;
        end
        else if (reversal)
        begin
            if ((motion_reg == arbc_pkg::REQ_UP && item_reg.up_lim) ||
                (motion_reg == arbc_pkg::REQ_DOWN && item_reg.down_lim))
                do_brake = 1'b1;
            else if (item_reg.rocking)
                do_slow = 1'b1;
            else
                do_brake = 1'b1;
        end
        else
        begin
            case (item_reg.req)
                arbc_pkg::REQ_DOWN:
                begin
                    if (item_reg.down_lim)
                    begin
                        do_brake   = 1'b1;
                        brake_end  = 1'b1;
                        zero_after = 1'b1;
                        item_done  = 1'b1;
                    end
                    else
                        do_up = 1'b1;
                end
                arbc_pkg::REQ_UP:
                begin
                    if (item_reg.up_lim)
                    begin
                        do_brake   = 1'b1;
                        brake_end  = 1'b1;
                        zero_after = 1'b1;
                        item_done  = 1'b1;
                    end
                    else
                        do_up = 1'b1;
                end
                arbc_pkg::REQ_IDLE:
                begin
                    do_brake  = 1'b1;
                    item_done = 1'b1;
                end
                default:
                    zero_after = 1'b1;
            endcase
        end
        brake_live = do_brake && flags_reg[arbc_pkg::FL_BRK];
        brake_div  = brake_live && (speed_reg > min_speed_reg) && brake_end && !zero_after;
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            arbc_pkg::ST_IDLE:
                if (in_valid)
                    state_next = arbc_pkg::ST_DECIDE;
            arbc_pkg::ST_DECIDE:
                if (brake_div)
                    state_next = arbc_pkg::ST_DIV;
                else if (slide)
                    state_next = arbc_pkg::ST_FINISH;
                else
                    state_next = arbc_pkg::ST_COMP;
            arbc_pkg::ST_DIV:
                if (div_cnt_reg == arbc_pkg::CNT_W'(1))
                begin
                    case (div_op_reg)
                        arbc_pkg::DOP_BRAKE: state_next = arbc_pkg::ST_BRAKE;
                        arbc_pkg::DOP_VOLT:  state_next = arbc_pkg::ST_MUL;
                        default:             state_next = arbc_pkg::ST_ROUND;
                    endcase
                end
            arbc_pkg::ST_BRAKE:
                state_next = slide ? arbc_pkg::ST_FINISH : arbc_pkg::ST_COMP;
            arbc_pkg::ST_COMP:
                state_next = ({1'b0, volt_scaled} <= set_voltage_reg) ?
                             arbc_pkg::ST_FINISH : arbc_pkg::ST_DIV;
            arbc_pkg::ST_MUL:
                state_next = arbc_pkg::ST_CHK;
            arbc_pkg::ST_CHK:
                state_next = (prod_reg >= arbc_pkg::SAT_PROD) ?
                             arbc_pkg::ST_FINISH : arbc_pkg::ST_DIV;
            arbc_pkg::ST_ROUND:
                state_next = arbc_pkg::ST_FINISH;
            arbc_pkg::ST_FINISH:
                if (commit)
                    state_next = arbc_pkg::ST_IDLE;
            default:
                state_next = arbc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- shared arithmetic ----------------
    assign rem_sh = {div_rem_reg, div_quo_reg[arbc_pkg::DIV_W-1]};
    assign div_ge = (rem_sh >= {1'b0, div_den_reg});

    assign up_base = (speed_reg < min_speed_reg) ? min_speed_reg : speed_reg;
    assign up_two  = {1'b0, up_base} + 17'd2;
    always_comb
    begin
        up_val = up_base;
        if (item_reg.rocking)
        begin
            if (duty_top_reg >= arbc_pkg::ROCK_MARGIN &&
                up_base < duty_top_reg - arbc_pkg::ROCK_MARGIN)
                up_val = up_base + 16'd1;
        end
        else if (up_base < duty_top_reg)
        begin
            up_val = (up_two > {1'b0, duty_top_reg}) ? duty_top_reg : up_two[15:0];
        end
    end

    always_comb
    begin
        slow_val = (speed_reg != '0) ? speed_reg - 16'd1 : speed_reg;
        if (slow_val < min_speed_reg)
            slow_val = '0;
    end

    // speed/20 in the quotient; speed/40 is that shifted once
    assign brake_dec = {1'b0, arbc_pkg::BRAKE_BIAS} + {2'b0, div_quo_reg[15:1]}
                       + {1'b0, div_quo_reg[15:0]};
    always_comb
    begin
        brake_val = (brake_dec >= {1'b0, speed_reg}) ? '0 : speed_reg - brake_dec[15:0];
        if (brake_val <= min_speed_reg)
            brake_val = '0;
    end

    assign clamp_val   = (speed_reg > duty_top_reg) ? duty_top_reg : speed_reg;
    assign volt_scaled = 23'(item_reg.volts) * 23'(arbc_pkg::VOLT_SCALE);
    assign prod_calc   = speed_reg * div_quo_reg;
    assign round_val   = div_quo_reg[16:0] +
                         17'(div_rem_reg > arbc_pkg::ROUND_HALF);

    // ---------------- datapath / outputs ----------------
    always_comb
    begin
        motion_next    = motion_reg;
        speed_next     = speed_reg;
        applied_next   = applied_reg;
        phase_next     = phase_reg;
        decay_next     = decay_reg;
        rline_next     = rline_reg;
        pos_next       = pos_reg;
        flags_next     = flags_reg;
        item_next      = item_reg;
        done_next      = done_reg;
        comp_next      = comp_reg;
        prod_next      = prod_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        div_op_next    = div_op_reg;
        o_duty_next    = o_duty_reg;
        o_speed_next   = o_speed_reg;
        o_dir_next     = o_dir_reg;
        o_decay_next   = o_decay_reg;
        o_rrel_next    = o_rrel_reg;
        o_pulse_next   = o_pulse_reg;
        o_done_next    = o_done_reg;
        o_pos_next     = o_pos_reg;
        o_pvalid_next  = o_pvalid_reg;
        o_pval_next    = o_pval_reg;
        out_valid_next = (out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg;

        case (state_reg)
            arbc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    item_next.req        = requested_state;
                    item_next.up_lim     = up_limit;
                    item_next.down_lim   = down_limit;
                    item_next.slide_back = slide_back_limit;
                    item_next.slide_fwd  = slide_fwd_limit;
                    item_next.rocking    = rocking;
                    item_next.rock_en    = rock_enable;
                    item_next.volts      = supply_voltage;
                    item_next.fault      = fault;
                    if (tick)
                        flags_next = arbc_pkg::FLAGS_ALL;
                end
            end
            arbc_pkg::ST_DECIDE:
            begin
                done_next = item_done;
                if (!slide)
                begin
                    if (reversal)
                    begin
                        if (speed_reg == '0)
                            motion_next = item_reg.req;
                    end
                    else
                    begin
                        motion_next = item_reg.req;
                        if (item_reg.req == arbc_pkg::REQ_DOWN && item_reg.down_lim)
                            pos_next = max_position_reg;
                        if (item_reg.req == arbc_pkg::REQ_UP && item_reg.up_lim)
                            pos_next = '0;
                    end
                end
                if (do_up)
                begin
                    rline_next = 1'b1;
                    phase_next = (item_reg.req == arbc_pkg::REQ_DOWN);
                    decay_next = 1'b0;
                    if (flags_reg[arbc_pkg::FL_UP])
                    begin
                        flags_next[arbc_pkg::FL_UP] = 1'b0;
                        speed_next = up_val;
                    end
                end
                if (do_slow && flags_reg[arbc_pkg::FL_SLOW])
                begin
                    flags_next[arbc_pkg::FL_SLOW] = 1'b0;
                    speed_next = slow_val;
                end
                if (brake_live)
                begin
                    flags_next[arbc_pkg::FL_BRK] = 1'b0;
                    if (speed_reg > min_speed_reg)
                    begin
                        if (!brake_end)
                        begin
                            decay_next = item_reg.rock_en;
                            speed_next = '0;
                        end
                        else if (zero_after)
                        begin
                            decay_next = 1'b0;
                            speed_next = '0;
                        end
                    end
                    else
                        speed_next = '0;
                end
                if (zero_after)
                    speed_next = '0;
                if (brake_div)
                begin
                    div_rem_next = '0;
                    div_quo_next = {speed_reg, 8'b0};
                    div_den_next = arbc_pkg::RATE_DIV;
                    div_cnt_next = arbc_pkg::STEPS_SPEED;
                    div_op_next  = arbc_pkg::DOP_BRAKE;
                end
            end
            arbc_pkg::ST_DIV:
            begin
                div_rem_next = div_ge ? 16'(rem_sh - {1'b0, div_den_reg}) : rem_sh[15:0];
                div_quo_next = {div_quo_reg[arbc_pkg::DIV_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg - 5'd1;
            end
            arbc_pkg::ST_BRAKE:
            begin
                speed_next = brake_val;
                decay_next = 1'b0;
            end
            arbc_pkg::ST_COMP:
            begin
                speed_next = clamp_val;
                comp_next  = clamp_val;
                div_rem_next = '0;
                div_quo_next = set_voltage_reg;
                div_den_next = item_reg.volts;
                div_cnt_next = arbc_pkg::STEPS_FULL;
                div_op_next  = arbc_pkg::DOP_VOLT;
            end
            arbc_pkg::ST_MUL:
                prod_next = prod_calc;
            arbc_pkg::ST_CHK:
            begin
                comp_next    = arbc_pkg::SAT_DUTY;
                div_rem_next = '0;
                div_quo_next = prod_reg[arbc_pkg::DIV_W-1:0];
                div_den_next = arbc_pkg::VOLT_SCALE;
                div_cnt_next = arbc_pkg::STEPS_FULL;
                div_op_next  = arbc_pkg::DOP_HUND;
            end
            arbc_pkg::ST_ROUND:
                comp_next = round_val[16] ? arbc_pkg::SAT_DUTY : round_val[15:0];
            arbc_pkg::ST_FINISH:
            begin
                if (commit)
                begin
                    o_pulse_next  = 1'b0;
                    o_pvalid_next = 1'b0;
                    o_pval_next   = '0;
                    if (slide)
                        applied_next = '0;
                    else
                    begin
                        if (comp_reg == '0)
                            applied_next = '0;
                        else if (comp_reg == applied_reg)
                        begin
                            if (item_reg.fault)
                            begin
                                rline_next   = 1'b1;
                                o_pulse_next = 1'b1;
                            end
                        end
                        else if (flags_reg[arbc_pkg::FL_PWM])
                        begin
                            flags_next[arbc_pkg::FL_PWM] = 1'b0;
                            applied_next = comp_reg;
                        end
                        if (item_reg.up_lim)
                            o_pvalid_next = 1'b1;
                        else if (item_reg.down_lim)
                        begin
                            o_pvalid_next = 1'b1;
                            o_pval_next   = preset_pos_reg;
                        end
                    end
                    if (flags_reg[arbc_pkg::FL_POS])
                    begin
                        flags_next[arbc_pkg::FL_POS] = 1'b0;
                        if (applied_next > min_speed_reg)
                        begin
                            if (!phase_reg)
                            begin
                                if (pos_reg != '0)
                                    pos_next = pos_reg - 16'd1;
                            end
                            else if (pos_reg < max_position_reg)
                                pos_next = pos_reg + 16'd1;
                        end
                    end
                    o_duty_next    = applied_next;
                    o_speed_next   = speed_reg;
                    o_dir_next     = phase_reg;
                    o_decay_next   = decay_reg;
                    o_rrel_next    = rline_next;
                    o_done_next    = done_reg;
                    o_pos_next     = pos_next;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                comp_next = comp_reg;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= arbc_pkg::ST_IDLE;
            duty_top_reg     <= arbc_pkg::RST_DUTY_TOP;
            min_speed_reg    <= arbc_pkg::RST_MIN_SPEED;
            max_position_reg <= arbc_pkg::RST_MAX_POSITION;
            preset_pos_reg   <= arbc_pkg::RST_PRESET_POS;
            set_voltage_reg  <= arbc_pkg::RST_SET_VOLTAGE;
            motion_reg       <= arbc_pkg::REQ_IDLE;
            speed_reg        <= '0;
            applied_reg      <= '0;
            phase_reg        <= 1'b0;
            decay_reg        <= 1'b0;
            rline_reg        <= 1'b0;
            pos_reg          <= '0;
            flags_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            motion_reg    <= motion_next;
            speed_reg     <= speed_next;
            applied_reg   <= applied_next;
            phase_reg     <= phase_next;
            decay_reg     <= decay_next;
            rline_reg     <= rline_next;
            pos_reg       <= pos_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    arbc_pkg::CFG_DUTY_TOP:     duty_top_reg     <= cfg_data[15:0];
                    arbc_pkg::CFG_MIN_SPEED:    min_speed_reg    <= cfg_data[15:0];
                    arbc_pkg::CFG_MAX_POSITION: max_position_reg <= cfg_data[15:0];
                    arbc_pkg::CFG_PRESET_POS:   preset_pos_reg   <= cfg_data[15:0];
                    arbc_pkg::CFG_SET_VOLTAGE:  set_voltage_reg  <= cfg_data;
                    default:                    set_voltage_reg  <= set_voltage_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        done_reg     <= done_next;
        comp_reg     <= comp_next;
        prod_reg     <= prod_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_den_reg  <= div_den_next;
        div_cnt_reg  <= div_cnt_next;
        div_op_reg   <= div_op_next;
        o_duty_reg   <= o_duty_next;
        o_speed_reg  <= o_speed_next;
        o_dir_reg    <= o_dir_next;
        o_decay_reg  <= o_decay_next;
        o_rrel_reg   <= o_rrel_next;
        o_pulse_reg  <= o_pulse_next;
        o_done_reg   <= o_done_next;
        o_pos_reg    <= o_pos_next;
        o_pvalid_reg <= o_pvalid_next;
        o_pval_reg   <= o_pval_next;
    end

    assign out_valid      = out_valid_reg;
    assign duty           = o_duty_reg;
    assign speed          = o_speed_reg;
    assign direction_down = o_dir_reg;
    assign decay_fast     = o_decay_reg;
    assign reset_released = o_rrel_reg;
    assign reset_pulse    = o_pulse_reg;
    assign done_res       = o_done_reg;
    assign position       = o_pos_reg;
    assign preset_valid   = o_pvalid_reg;
    assign preset_value   = o_pval_reg;

`ifndef SYNTH
    a_pulse_released: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reset_pulse) |-> (reset_released && duty != '0))
        else $error("fault pulse without released reset or with zero duty");

    a_preset_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !preset_valid) |-> (preset_value == '0))
        else $error("preset value set without preset valid");

    a_commit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == arbc_pkg::ST_IDLE && out_valid))
        else $error("result commit did not return sequencer to idle");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == arbc_pkg::ST_DIV) |-> (div_cnt_reg != '0))
        else $error("divider running with zero step count");
`endif

endmodule
